### design/sq90_pkg.sv
// ----------------------------------------------------------------------------
// sq90_pkg
// Shared sizes, types and constants of the square image 90-degree rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package sq90_pkg;

  // frame geometry and pixel width
  localparam int MAX_N      = 64;
  localparam int PIXEL_BITS = 32;

  // port field widths
  localparam int CFG_W = 7;
  localparam int PIX_W = 32;

  // derived widths
  localparam int POS_W  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int N_W    = $clog2(MAX_N + 1);
  localparam int SZ_W   = (CFG_W > N_W) ? CFG_W : N_W;
  localparam int DEPTH  = MAX_N * MAX_N;
  localparam int ADDR_W = $clog2(DEPTH);

  // side length after reset
  localparam logic [CFG_W-1:0] MATRIX_SIZE_RST = CFG_W'(64);

  typedef logic [CFG_W-1:0]      cfg_t;
  typedef logic [PIX_W-1:0]      port_pix_t;
  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [N_W-1:0]        size_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  // per-transfer addressing info from the position tracker
  typedef struct packed {
    addr_t wr_addr;
    addr_t rd_addr;
    logic  bank_sel;
    logic  prior_ready;
    logic  last;
  } step_t;

endpackage

`default_nettype wire

### design/sq90_ram.sv
// ----------------------------------------------------------------------------
// sq90_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sq90_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/sq90_pos_track.sv
// ----------------------------------------------------------------------------
// sq90_pos_track
// Holds the side length, row/column position, bank select and prior-frame
// flag; produces write and rotated read addresses for the current transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module sq90_pos_track (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire sq90_pkg::cfg_t cfg_wr_data,
  input  wire logic          step_en,
  output sq90_pkg::step_t    step
);
  import sq90_pkg::*;

  cfg_t  size_r;
  pos_t  row_r, row_nxt;
  pos_t  col_r, col_nxt;
  logic  bank_r, bank_nxt;
  logic  prior_r, prior_nxt;

  logic [SZ_W-1:0] size_ext;
  size_t n;
  size_t n_m1;
  pos_t  row_eff;
  pos_t  col_eff;
  pos_t  src_row;
  logic  col_end;
  logic  row_end;

  // clamp the side length into 1..MAX_N
  always_comb begin
    size_ext = SZ_W'(size_r);
    if (size_ext == '0) begin
      n = N_W'(1);
    end else if (size_ext > SZ_W'(MAX_N)) begin
      n = N_W'(MAX_N);
    end else begin
      n = N_W'(size_ext);
    end
    n_m1 = n - N_W'(1);
  end

  // effective position, rotated source and addresses
  always_comb begin
    if ((N_W'(row_r) >= n) || (N_W'(col_r) >= n)) begin
      row_eff = '0;
      col_eff = '0;
    end else begin
      row_eff = row_r;
      col_eff = col_r;
    end
    col_end = (N_W'(col_eff) == n_m1);
    row_end = (N_W'(row_eff) == n_m1);
    src_row = POS_W'(n_m1 - N_W'(col_eff));

    step.wr_addr     = ADDR_W'(ADDR_W'(row_eff) * ADDR_W'(MAX_N) + ADDR_W'(col_eff));
    step.rd_addr     = ADDR_W'(ADDR_W'(src_row) * ADDR_W'(MAX_N) + ADDR_W'(row_eff));
    step.bank_sel    = bank_r;
    step.prior_ready = prior_r;
    step.last        = row_end && col_end;
  end

  // next position, bank swap at frame end
  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    bank_nxt  = bank_r;
    prior_nxt = prior_r;
    if (cfg_wr_en) begin
      row_nxt   = '0;
      col_nxt   = '0;
      prior_nxt = 1'b0;
    end else if (step_en) begin
      if (col_end) begin
        col_nxt = '0;
        if (row_end) begin
          row_nxt   = '0;
          bank_nxt  = ~bank_r;
          prior_nxt = 1'b1;
        end else begin
          row_nxt = row_eff + POS_W'(1);
        end
      end else begin
        row_nxt = row_eff;
        col_nxt = col_eff + POS_W'(1);
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= MATRIX_SIZE_RST;
      row_r   <= '0;
      col_r   <= '0;
      bank_r  <= 1'b0;
      prior_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      bank_r  <= bank_nxt;
      prior_r <= prior_nxt;
    end
  end

endmodule

`default_nettype wire

### design/square_image_rotate_90_unit.sv
// ----------------------------------------------------------------------------
// square_image_rotate_90_unit
// Streams square N x N frames in row-major order and emits each frame
// rotated 90 degrees clockwise, one frame behind, via two ping-pong banks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_pixel_in carries one pixel per transfer.
//   Output channel out_valid/out_ready carries out_pixel_out and out_frame_last.
//   cfg_wr_en/cfg_wr_data set the side length N (0 acts as 1, above MAX_N acts
//   as MAX_N); a write restarts the stream at the frame start.
//   Each input pixel is written into one bank while the matching pixel of the
//   rotated previous frame is read from the other bank. The first frame after
//   reset or after a size write yields no output.
//   Throughput: one pixel per cycle in and out while out_ready stays high;
//   each transfer costs one write and, once a prior frame is held, one read,
//   on different banks. Each output passes the bank read register, then the
//   output register.
//   Reset (synchronous, rst_n low) clears position, bank select, prior-frame
//   flag and pipeline valids; N returns to 64. The banks are not cleared.
//   When the receiver stalls, the read stage and output register hold up to
//   two results; in_ready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module square_image_rotate_90_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire sq90_pkg::cfg_t     cfg_wr_data,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire sq90_pkg::port_pix_t in_pixel_in,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      sq90_pkg::port_pix_t out_pixel_out,
  output      logic               out_frame_last
);
  import sq90_pkg::*;

  step_t step;
  logic  in_xfer;
  logic  rd_issue;
  pix_t  wr_pix;
  pix_t  rd_data0;
  pix_t  rd_data1;

  logic  s1_vld_r, s1_vld_nxt;
  logic  s1_last_r;
  logic  s1_bank_r;
  logic  s1_adv;
  logic  out_vld_r, out_vld_nxt;
  port_pix_t out_pix_r;
  logic  out_last_r;

  // handshake
  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || !out_vld_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign rd_issue = in_xfer && step.prior_ready;
  assign wr_pix   = PIXEL_BITS'(in_pixel_in);

  // position and address tracking
  sq90_pos_track u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (in_xfer),
    .step        (step)
  );

  // ping-pong frame banks
  sq90_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_bank0 (
    .clk     (clk),
    .wr_en   (in_xfer && !step.bank_sel),
    .wr_addr (step.wr_addr),
    .wr_data (wr_pix),
    .rd_en   (rd_issue && step.bank_sel),
    .rd_addr (step.rd_addr),
    .rd_data (rd_data0)
  );

  sq90_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_bank1 (
    .clk     (clk),
    .wr_en   (in_xfer && step.bank_sel),
    .wr_addr (step.wr_addr),
    .wr_data (wr_pix),
    .rd_en   (rd_issue && !step.bank_sel),
    .rd_addr (step.rd_addr),
    .rd_data (rd_data1)
  );

  // pipeline valid updates
  always_comb begin
    if (rd_issue) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end

    if (s1_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // read stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      s1_last_r <= step.last;
      s1_bank_r <= step.bank_sel;
    end
    if (s1_adv) begin
      out_pix_r  <= s1_bank_r ? PIX_W'(rd_data0) : PIX_W'(rd_data1);
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_pixel_out  = out_pix_r;
  assign out_frame_last = out_last_r;

endmodule

`default_nettype wire

### tb/square_image_rotate_90_unit_test.sv
// ----------------------------------------------------------------------------
// square_image_rotate_90_unit_test
// Streams square frames of random pixels through the rotator at several side
// lengths and checks every rotated pixel and its frame-end flag against an
// in-bench ping-pong frame store, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module square_image_rotate_90_unit_test;
  import sq90_pkg::*;

  typedef struct packed {
    port_pix_t pixel;
    logic      last;
  } rotated_px_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_wr_en = 1'b0;
  cfg_t      cfg_wr_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  port_pix_t in_pixel_in = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  port_pix_t out_pixel_out;
  logic      out_frame_last;

  // pixels waiting to be offered, rotated pixels waiting to come out
  port_pix_t   pixel_feed [$];
  rotated_px_t rotated_q [$];
  rotated_px_t want_px;
  int unsigned mismatches = 0;
  int unsigned rotated_seen = 0;

  // frame store copy: two banks, write bank, raster position, side length
  pix_t        bank_zero [DEPTH];
  pix_t        bank_one [DEPTH];
  logic        wr_bank = 1'b0;
  int unsigned pos_row = 0;
  int unsigned pos_col = 0;
  logic        prev_frame_held = 1'b0;
  cfg_t        side_reg = MATRIX_SIZE_RST;

  square_image_rotate_90_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_frame_last (out_frame_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // side length in use, clamped into 1..MAX_N
  function automatic int unsigned side_len();
    int unsigned n;
    n = side_reg;
    if (n < 1) n = 1;
    if (n > MAX_N) n = MAX_N;
    return n;
  endfunction

  // a size write restarts the stream, bank choice is kept
  function automatic void set_side(cfg_t v);
    side_reg = v;
    pos_row = 0;
    pos_col = 0;
    prev_frame_held = 1'b0;
  endfunction

  // store one incoming pixel and queue the rotated pixel of the prior frame
  function automatic void rotate_pixel(port_pix_t pix);
    int unsigned n;
    int unsigned row;
    int unsigned col;
    int unsigned src;
    rotated_px_t res;
    n = side_len();
    row = pos_row;
    col = pos_col;
    if (row >= n || col >= n) begin
      row = 0;
      col = 0;
    end
    if (prev_frame_held) begin
      // output (r,c) comes from previous input (n-1-c, r)
      src = (n - 1 - col) * MAX_N + row;
      res.pixel = port_pix_t'(wr_bank ? bank_zero[src] : bank_one[src]);
      res.last = (row == n - 1) && (col == n - 1);
      rotated_q.push_back(res);
    end
    if (wr_bank) bank_one[row * MAX_N + col] = pix_t'(pix);
    else bank_zero[row * MAX_N + col] = pix_t'(pix);
    // advance raster position, swap banks at frame end
    if (col + 1 >= n) begin
      col = 0;
      if (row + 1 >= n) begin
        row = 0;
        wr_bank = ~wr_bank;
        prev_frame_held = 1'b1;
      end else begin
        row++;
      end
    end else begin
      col++;
    end
    pos_row = row;
    pos_col = col;
  endfunction

  // pixel sender: bursts of random length separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) rotate_pixel(in_pixel_in);
      if (!(in_valid && !in_ready)) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pixel_feed.size() != 0) begin
          in_valid <= 1'b1;
          in_pixel_in <= pixel_feed.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            case ($urandom_range(0, 7))
              0, 1:    gap_left <= 0;
              2:       gap_left <= $urandom_range(7, 20);
              default: gap_left <= $urandom_range(1, 6);
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each transfer, stalls on a changing pattern
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 40;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (out_valid && out_ready) begin
        rotated_seen++;
        if (rotated_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual pixel %h last %b",
                   $time, out_pixel_out, out_frame_last);
        end else begin
          want_px = rotated_q.pop_front();
          if (out_pixel_out !== want_px.pixel) begin
            mismatches++;
            $display("%0t: pixel_out mismatch: expected %h, actual %h",
                     $time, want_px.pixel, out_pixel_out);
          end
          if (out_frame_last !== want_px.last) begin
            mismatches++;
            $display("%0t: frame_last mismatch: expected %b, actual %b",
                     $time, want_px.last, out_frame_last);
          end
        end
      end
      // long hold-off while pixels keep coming, so the block backs up
      if (rotated_seen >= next_hold_at && hold_left == 0 && pixel_feed.size() > 20) begin
        next_hold_at += 4000;
        hold_left = 150;
      end
      if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= (rx_cycle % 5 != 0);
          default: out_ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // write the side length register while the block is idle
  task automatic write_side(cfg_t v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    set_side(v);
  endtask

  task automatic feed_random(int unsigned count);
    repeat (count) pixel_feed.push_back($urandom());
  endtask

  // wait until every pixel is taken and every rotated pixel is back
  task automatic settle();
    int unsigned waited;
    waited = 0;
    while ((pixel_feed.size() != 0 || in_valid || rotated_q.size() != 0)
           && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned side;
    int unsigned n;
    int unsigned frames;
    int unsigned count;
    int unsigned random_items;
    int unsigned sel;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset size, first frame only: nothing comes out
    pixel_feed.push_back(32'h0000_0000);
    pixel_feed.push_back(32'hFFFF_FFFF);
    pixel_feed.push_back(32'h8000_0001);
    pixel_feed.push_back(32'h7FFF_FFFE);
    settle();

    // size zero acts as single-pixel frames
    write_side(cfg_t'(0));
    pixel_feed.push_back(32'hFFFF_FFFF);
    pixel_feed.push_back(32'h0000_0000);
    pixel_feed.push_back(32'hFFFF_FFFF);
    pixel_feed.push_back(32'hA5A5_5A5A);
    settle();

    // 2x2 frames with extreme pixels, two frames and one more pixel
    write_side(cfg_t'(2));
    pixel_feed.push_back(32'h1111_1111);
    pixel_feed.push_back(32'hFFFF_FFFF);
    pixel_feed.push_back(32'h0000_0000);
    pixel_feed.push_back(32'h8000_0000);
    pixel_feed.push_back(32'h0000_0001);
    pixel_feed.push_back(32'h0000_0002);
    pixel_feed.push_back(32'h0000_0003);
    pixel_feed.push_back(32'h0000_0004);
    pixel_feed.push_back(32'h0F0F_0F0F);
    settle();

    // partial frame, then the same size again restarts the stream
    write_side(cfg_t'(3));
    feed_random(5);
    settle();
    write_side(cfg_t'(3));
    feed_random(3);
    settle();

    // size above max clamps to full frames: a partial frame yields nothing
    write_side(cfg_t'(127));
    feed_random(MAX_N + 7);
    settle();

    // random sizes, mostly small, whole frames plus a broken tail
    random_items = 0;
    while (random_items < 450) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) side = 0;
      else if (sel < 14) side = $urandom_range(1, 5);
      else side = $urandom_range(6, 10);
      n = (side == 0) ? 1 : side;
      frames = $urandom_range(0, 4);
      count = frames * n * n + $urandom_range(0, n * n - 1);
      if (count == 0) count = 1;
      write_side(cfg_t'(side));
      feed_random(count);
      settle();
      random_items += count;
    end

    repeat (10) @(posedge clk);
    if (rotated_q.size() != 0) begin
      mismatches += rotated_q.size();
      $display("%0t: missing results: expected %0d more, actual 0",
               $time, rotated_q.size());
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### square_image_rotate_90_unit.f
design/sq90_pkg.sv
design/sq90_ram.sv
design/sq90_pos_track.sv
design/square_image_rotate_90_unit.sv
tb/square_image_rotate_90_unit_test.sv
